[rtl/gtb_pkg.sv]
// ----------------------------------------------------------------------------
// gtb_pkg: shared types and constants for the GELU backward pipeline
// Word formats, fixed-point constants, the tanh node table and the
// rounding helper used by the datapath.
// ----------------------------------------------------------------------------
package gtb_pkg;

    typedef struct packed {
        logic signed [15:0] up_grad;
        logic signed [15:0] act_in;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] grad_in;
        logic               last_out;
    } t_out_word;

    localparam int NUM_STAGES = 13;

    localparam logic [16:0]        Q_ONE16       = 17'd65536;
    localparam logic signed [17:0] BETA_Q16      = 18'sd52290;
    localparam logic signed [13:0] KAPPA_Q16     = 14'sd2930;
    localparam logic [13:0]        KAPPA3_Q16    = 14'd8791;
    localparam logic [14:0]        HALF_BETA_Q16 = 15'd26145;
    localparam logic [63:0]        EXP_STEP_Q24  = 64'd19011076;
    localparam int                 TANH_SEGS     = 64;

    typedef logic [16:0] t_node;
    typedef t_node [TANH_SEGS:0] t_node_tab;

    // Node k is tanh(k/16) in Q.16, built from e^(k/8) in Q.24 by a rounded
    // recurrence. The quotient is found by shift and subtract at elaboration.
    function automatic t_node_tab build_tanh_nodes();
        logic [63:0] e;
        logic [63:0] one;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        t_node       q;
        t_node_tab   tab;
        one = 64'd1 << 24;
        e   = one;
        for (int k = 0; k <= TANH_SEGS; k++) begin
            num = (e - one) * 64'd65536;
            den = e + one;
            rem = num + (den >> 1);
            q   = '0;
            for (int b = 16; b >= 0; b--) begin
                if (rem >= (den << b)) begin
                    rem  = rem - (den << b);
                    q[b] = 1'b1;
                end
            end
            tab[k] = q;
            e = (e * EXP_STEP_Q24 + (64'd1 << 23)) >> 24;
        end
        return tab;
    endfunction

    localparam t_node_tab TANH_NODES = build_tanh_nodes();

    // Shift right by s with rounding to nearest, ties away from zero.
    function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
                                                      input int s);
        logic [47:0] m;
        logic [47:0] r;
        m = v[47] ? 48'(-v) : 48'(v);
        r = (m + (48'd1 << (s - 1))) >> s;
        return v[47] ? -$signed(r) : $signed(r);
    endfunction

endpackage

[rtl/gelu_tanh_backward.sv]
// ----------------------------------------------------------------------------
// gelu_tanh_backward: gradient of the tanh-approximated GELU
// Returns up_grad * GELU'(act_in) in Q4.12, one word per element.
// ----------------------------------------------------------------------------
// Pipeline: 13 register stages, each with its own valid bit.
// Throughput: one word per cycle; most stages hold one multiply, tanh a lookup.
// The input stalls only when all 13 stages hold words and the output is held.
// Every stage stalls on its own, so bubbles close up under back-pressure.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
module gelu_tanh_backward (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gtb_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gtb_pkg::t_out_word  o_out_data
);

    localparam int NS = gtb_pkg::NUM_STAGES;

    // Side data that rides along with each element. The poly and cdf2
    // fields are filled in by the stage that produces them.
    typedef struct packed {
        logic signed [15:0] g;
        logic signed [15:0] x;
        logic [19:0]        poly;
        logic [17:0]        cdf2;
        logic               last;
    } t_side;

    logic [NS:1] r_vld;
    logic [NS:1] w_adv;
    t_side       r_side [1:NS-1];

    // Stage payload registers.
    logic [30:0]        r1_xx;
    logic signed [35:0] r2_px3;
    logic [32:0]        r2_ppoly;
    logic signed [35:0] r3_pk;
    logic signed [34:0] r4_pz;
    logic [16:0]        r5_mag;
    logic               r5_neg;
    logic [16:0]        r6_tmag;
    logic               r6_neg;
    logic [32:0]        r7_tt;
    logic [36:0]        r8_psp;
    logic [34:0]        r9_pp2;
    logic signed [34:0] r10_ppdf;
    logic signed [23:0] r11_d;
    logic signed [39:0] r12_pgd;
    gtb_pkg::t_out_word r13_out;

    // Combinational values between stages.
    logic [18:0]        w_x2;
    logic signed [47:0] w_x3_full;
    logic signed [22:0] w_x3;
    logic [19:0]        w_poly;
    t_side              w_side3;
    logic signed [47:0] w_kx3_full;
    logic signed [17:0] w_u;
    logic signed [47:0] w_z_full;
    logic signed [17:0] w_z;
    logic [16:0]        w_tmag;
    logic [17:0]        w_cdf2;
    t_side              w_side7;
    logic [16:0]        w_sech;
    logic [19:0]        w_p1;
    logic [17:0]        w_p2;
    logic signed [47:0] w_pdf_full;
    logic signed [21:0] w_pdf;
    logic signed [47:0] w_res_full;
    logic signed [15:0] w_res;

    // A stage may load when it or any stage after it holds a bubble, or
    // when the output word is being taken.
    always_comb begin
        for (int k = 1; k <= NS; k++) begin
            w_adv[k] = i_out_ready || ((r_vld >> (k - 1)) != ({NS{1'b1}} >> (k - 1)));
        end
    end

    assign o_in_ready  = w_adv[1];
    assign o_out_valid = r_vld[NS];
    assign o_out_data  = r13_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    // The tanh interpolation sits between the |z| register and the t register.
    gtb_tanh u_tanh (
        .i_mag  (r5_mag),
        .o_tmag (w_tmag)
    );

    always_comb begin
        // Stage 2: x^2 rounded to Q.12.
        w_x2       = 19'((32'(r1_xx) + 32'd2048) >> 12);
        // Stage 3: x^3 and the polynomial term 1 + 3*kappa*x^2 in Q.16.
        w_x3_full  = gtb_pkg::rnd_shift(48'(r2_px3), 12);
        w_x3       = $signed(w_x3_full[22:0]);
        w_poly     = 20'(21'(gtb_pkg::Q_ONE16) + 21'((34'(r2_ppoly) + 34'd2048) >> 12));
        w_side3      = r_side[2];
        w_side3.poly = w_poly;
        // Stage 4: u = x + kappa*x^3.
        w_kx3_full = gtb_pkg::rnd_shift(48'(r3_pk), 16);
        w_u        = 18'(r_side[3].x) + $signed(w_kx3_full[17:0]);
        // Stage 5: z = beta*u, split into magnitude and sign.
        w_z_full   = gtb_pkg::rnd_shift(48'(r4_pz), 16);
        w_z        = $signed(w_z_full[17:0]);
        // Stage 7: 1 + tanh(z) in Q.16, which is twice the Gaussian CDF term.
        w_cdf2     = r6_neg ? 18'(18'(gtb_pkg::Q_ONE16) - 18'(r6_tmag))
                            : 18'(18'(gtb_pkg::Q_ONE16) + 18'(r6_tmag));
        w_side7      = r_side[6];
        w_side7.cdf2 = w_cdf2;
        // Stage 8: sech^2 = 1 - tanh^2.
        w_sech     = 17'(gtb_pkg::Q_ONE16 - 17'((34'(r7_tt) + 34'd32768) >> 16));
        // Stages 9 and 10: scale by the polynomial and by beta/2.
        w_p1       = 20'((38'(r8_psp) + 38'd32768) >> 16);
        w_p2       = 18'((36'(r9_pp2) + 36'd32768) >> 16);
        // Stage 11: times x gives the density term.
        w_pdf_full = gtb_pkg::rnd_shift(48'(r10_ppdf), 12);
        w_pdf      = $signed(w_pdf_full[21:0]);
        // Stage 13: final rounding and saturation to Q4.12.
        w_res_full = gtb_pkg::rnd_shift(48'(r12_pgd), 17);
        if (w_res_full > 48'sd32767) begin
            w_res = 16'sh7fff;
        end else if (w_res_full < -48'sd32768) begin
            w_res = 16'sh8000;
        end else begin
            w_res = $signed(w_res_full[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_side[1].g    <= i_in_data.up_grad;
            r_side[1].x    <= i_in_data.act_in;
            r_side[1].last <= i_in_data.last;
            r_side[1].poly <= '0;
            r_side[1].cdf2 <= '0;
            r1_xx          <= 31'(i_in_data.act_in * i_in_data.act_in);
        end
        if (w_adv[2]) begin
            r_side[2] <= r_side[1];
            r2_px3    <= $signed({1'b0, w_x2}) * r_side[1].x;
            r2_ppoly  <= 33'(w_x2) * 33'(gtb_pkg::KAPPA3_Q16);
        end
        if (w_adv[3]) begin
            r_side[3] <= w_side3;
            r3_pk     <= w_x3 * gtb_pkg::KAPPA_Q16;
        end
        if (w_adv[4]) begin
            r_side[4] <= r_side[3];
            r4_pz     <= w_u * gtb_pkg::BETA_Q16;
        end
        if (w_adv[5]) begin
            r_side[5] <= r_side[4];
            r5_neg    <= w_z[17];
            r5_mag    <= w_z[17] ? 17'(-w_z) : 17'(w_z);
        end
        if (w_adv[6]) begin
            r_side[6] <= r_side[5];
            r6_neg    <= r5_neg;
            r6_tmag   <= w_tmag;
        end
        if (w_adv[7]) begin
            r_side[7] <= w_side7;
            r7_tt     <= 33'(r6_tmag) * 33'(r6_tmag);
        end
        if (w_adv[8]) begin
            r_side[8] <= r_side[7];
            r8_psp    <= 37'(w_sech) * 37'(r_side[7].poly);
        end
        if (w_adv[9]) begin
            r_side[9] <= r_side[8];
            r9_pp2    <= 35'(w_p1) * 35'(gtb_pkg::HALF_BETA_Q16);
        end
        if (w_adv[10]) begin
            r_side[10] <= r_side[9];
            r10_ppdf   <= $signed({1'b0, w_p2}) * r_side[9].x;
        end
        if (w_adv[11]) begin
            r_side[11] <= r_side[10];
            r11_d      <= $signed(24'(r_side[10].cdf2)) + (24'(w_pdf) <<< 1);
        end
        if (w_adv[12]) begin
            r_side[12] <= r_side[11];
            r12_pgd    <= r_side[11].g * r11_d;
        end
        if (w_adv[13]) begin
            r13_out.grad_in  <= w_res;
            r13_out.last_out <= r_side[12].last;
        end
    end

endmodule

[rtl/gtb_tanh.sv]
// ----------------------------------------------------------------------------
// gtb_tanh: piecewise-linear tanh magnitude
// Maps |z| in Q.12 to tanh(|z|) in Q.16 over 64 segments, saturating to one.
// ----------------------------------------------------------------------------
module gtb_tanh (
    input  logic [16:0] i_mag,
    output logic [16:0] o_tmag
);

    logic [5:0]         w_seg;
    logic [7:0]         w_frac;
    logic [16:0]        w_n0;
    logic [16:0]        w_n1;
    logic signed [17:0] w_diff;
    logic signed [26:0] w_prod;
    logic signed [18:0] w_step;

    always_comb begin
        w_seg  = i_mag[13:8];
        w_frac = i_mag[7:0];
        w_n0   = gtb_pkg::TANH_NODES[{1'b0, w_seg}];
        w_n1   = gtb_pkg::TANH_NODES[{1'b0, w_seg} + 7'd1];
        w_diff = $signed({1'b0, w_n1}) - $signed({1'b0, w_n0});
        w_prod = w_diff * $signed({1'b0, w_frac});
        w_step = 19'((w_prod + 27'sd128) >>> 8);
        if (i_mag[16:14] != 3'd0) begin
            o_tmag = gtb_pkg::Q_ONE16;
        end else begin
            o_tmag = 17'($signed({2'b00, w_n0}) + w_step);
        end
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the GELU tanh backward pipeline
// Drives upstream gradient and activation words into gelu_tanh_backward,
// predicts every output word with an independent fixed-point model of the
// tanh-approximated GELU derivative, and checks each result in order while
// both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    // Fixed-point constants of the derivative, all in Q.16.
    localparam longint UNIT_FX      = 65536;
    localparam longint BETA_FX      = 52290;
    localparam longint KAPPA_FX     = 2930;
    localparam longint KAPPA3_FX    = 8791;
    localparam longint HALF_BETA_FX = 26145;
    // tanh saturates from |z| = 4.0 on; z is held in Q.12.
    localparam longint TANH_EDGE_FX = 16384;
    localparam int     TANH_NODES_N = 64;

    localparam int CLK_HALF      = 6;
    localparam int RANDOM_WORDS  = 1700;
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 250;
    localparam int LIMIT_CYCLES  = 200000;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the output word for every accepted input word and
    // compares results against the oldest prediction still waiting.
    // ------------------------------------------------------------------------
    class grad_scoreboard;

        typedef struct {
            gtb_pkg::t_in_word  src;
            gtb_pkg::t_out_word want;
        } t_pending;

        longint   tanh_tab [TANH_NODES_N + 1];
        t_pending waiting [$];
        int       errors;

        // The tanh nodes sit at z = k/16. e^(k/8) is stepped in Q.24 and the
        // ratio (E-1)/(E+1) is rounded half up into Q.16.
        function new();
            bit [63:0] e;
            bit [63:0] unit;
            bit [63:0] num;
            bit [63:0] den;
            unit   = 64'd1 << 24;
            e      = unit;
            errors = 0;
            for (int k = 0; k <= TANH_NODES_N; k++) begin
                num         = (e - unit) * 64'd65536;
                den         = e + unit;
                tanh_tab[k] = longint'((num + den / 64'd2) / den);
                e           = (e * 64'd19011076 + (64'd1 << 23)) >> 24;
            end
        endfunction

        // Rounding right shift, ties away from zero.
        function longint round_shr(longint v, int s);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (longint'(1) << (s - 1))) >>> s;
            return (v < 0) ? -m : m;
        endfunction

        // Piecewise-linear tanh, z in Q.12, result in Q.16.
        function longint tanh_fx(longint z);
            longint a;
            longint f;
            longint t;
            int     i;
            a = (z < 0) ? -z : z;
            if (a >= TANH_EDGE_FX) begin
                t = UNIT_FX;
            end else begin
                i = int'(a >>> 8) & (TANH_NODES_N - 1);
                f = a & 255;
                t = tanh_tab[i] + (((tanh_tab[i + 1] - tanh_tab[i]) * f + 128) >>> 8);
            end
            return (z < 0) ? -t : t;
        endfunction

        function gtb_pkg::t_out_word gelu_grad(gtb_pkg::t_in_word w);
            longint             g, x, x2, x3, u, z, t;
            longint             cdf2, sech, poly, p1, p2, pdf, d, r;
            gtb_pkg::t_out_word o;
            g    = $signed(w.up_grad);
            x    = $signed(w.act_in);
            x2   = round_shr(x * x, 12);
            x3   = round_shr(x2 * x, 12);
            u    = x + round_shr(KAPPA_FX * x3, 16);
            z    = round_shr(BETA_FX * u, 16);
            t    = tanh_fx(z);
            // cdf2 is twice the CDF term, so d below is GELU'(x) in Q.17.
            cdf2 = UNIT_FX + t;
            sech = UNIT_FX - round_shr(t * t, 16);
            poly = UNIT_FX + round_shr(KAPPA3_FX * x2, 12);
            p1   = round_shr(sech * poly, 16);
            p2   = round_shr(p1 * HALF_BETA_FX, 16);
            pdf  = round_shr(p2 * x, 12);
            d    = cdf2 + 2 * pdf;
            r    = round_shr(g * d, 17);
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            o.grad_in  = r[15:0];
            o.last_out = w.last;
            return o;
        endfunction

        function void note_input(gtb_pkg::t_in_word w);
            t_pending p;
            p.src  = w;
            p.want = gelu_grad(w);
            waiting.push_back(p);
        endfunction

        // One line per mismatch, and every one is counted.
        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(gtb_pkg::t_out_word got);
            t_pending p;
            if (waiting.size() == 0) begin
                report($sformatf("unexpected word grad_in=%0d last_out=%0b",
                                 got.grad_in, got.last_out));
            end else begin
                p = waiting.pop_front();
                if (got.grad_in !== p.want.grad_in)
                    report($sformatf("grad_in %0d, want %0d (g=%0d x=%0d)",
                                     got.grad_in, p.want.grad_in,
                                     p.src.up_grad, p.src.act_in));
                if (got.last_out !== p.want.last_out)
                    report($sformatf("last_out %0b, want %0b (g=%0d x=%0d)",
                                     got.last_out, p.want.last_out,
                                     p.src.up_grad, p.src.act_in));
            end
        endtask

        task flag_leftovers();
            if (waiting.size() != 0)
                report($sformatf("%0d words never came out", waiting.size()));
        endtask

    endclass

    // ------------------------------------------------------------------------
    // Block under test and its connections.
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    gtb_pkg::t_in_word  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    gtb_pkg::t_out_word o_out_data;

    grad_scoreboard board;
    int unsigned    n_accepted;

    gelu_tanh_backward uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Handshakes are sampled at the rising edge, before the block's own
    // updates of that edge land. Inputs are noted before results are checked,
    // although the pipeline depth keeps the two apart anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                board.note_input(i_in_data);
                n_accepted++;
            end
            if (o_out_valid && i_out_ready)
                board.check_result(o_out_data);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Each word is offered at a falling edge and held until an
    // accepting rising edge. Consecutive words in a burst keep valid high;
    // only a gap lowers it.
    // ------------------------------------------------------------------------
    task automatic send_word(input gtb_pkg::t_in_word w);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    function automatic gtb_pkg::t_in_word make_word(input int g, input int x,
                                                    input bit lst);
        gtb_pkg::t_in_word w;
        w.up_grad = g[15:0];
        w.act_in  = x[15:0];
        w.last    = lst;
        return w;
    endfunction

    // Random words lean on the interesting regions: the curved part of the
    // derivative, the neighborhood where tanh saturates, and large gradients
    // near the derivative's peak and trough, so the output saturates at the peak.
    function automatic gtb_pkg::t_in_word random_word();
        gtb_pkg::t_in_word w;
        int                kind;
        int                mag;
        kind      = $urandom_range(0, 99);
        w.up_grad = 16'($urandom);
        w.act_in  = 16'($urandom);
        w.last    = ($urandom_range(0, 15) == 0);
        if (kind >= 40 && kind < 70) begin
            w.act_in = 16'(int'($urandom_range(0, 40960)) - 20480);
        end else if (kind >= 70 && kind < 85) begin
            mag      = $urandom_range(11000, 12800);
            w.act_in = 16'($urandom_range(0, 1) ? mag : -mag);
        end else if (kind >= 85) begin
            mag       = $urandom_range(4000, 12000);
            w.act_in  = 16'($urandom_range(0, 1) ? mag : -mag);
            mag       = $urandom_range(24576, 32768);
            w.up_grad = 16'($urandom_range(0, 1) ? mag - 1 : -mag);
        end
        return w;
    endfunction

    // Directed words: field extremes, the origin, both tails where tanh is
    // flat, the saturation edge region, output saturation in both directions
    // and the last flag in both states.
    task automatic directed_part();
        send_word(make_word(4096, 0, 1'b0));
        send_word(make_word(4096, 4096, 1'b0));
        send_word(make_word(4096, -4096, 1'b0));
        send_word(make_word(4096, 1, 1'b0));
        send_word(make_word(4096, -1, 1'b1));
        send_word(make_word(32767, 32767, 1'b0));
        send_word(make_word(-32768, 32767, 1'b0));
        send_word(make_word(32767, -32768, 1'b0));
        send_word(make_word(-32768, -32768, 1'b1));
        send_word(make_word(0, 12000, 1'b0));
        send_word(make_word(4096, 11800, 1'b0));
        send_word(make_word(4096, -11800, 1'b0));
        send_word(make_word(4096, 12100, 1'b0));
        send_word(make_word(4096, 16384, 1'b0));
        send_word(make_word(4096, -16384, 1'b0));
        // Derivative above one near x = 2 drives the product out of range.
        send_word(make_word(32767, 8192, 1'b0));
        send_word(make_word(-32768, 8192, 1'b0));
        // Negative derivative near x = -2.4 flips the sign of the gradient.
        send_word(make_word(-32768, -9830, 1'b0));
        send_word(make_word(32767, -9830, 1'b1));
        send_word(make_word(-1, -1, 1'b0));
        send_word(make_word(1, 6000, 1'b0));
        send_word(make_word(12345, -2000, 1'b0));
        send_word(make_word(-4096, 2000, 1'b1));
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. The ready pattern rotates through four moods: always
    // ready, coin flip, mostly stalled and a short periodic pattern. Once,
    // after a few hundred words have gone in, ready is held low for a long
    // stretch while the sender keeps offering, so the pipeline fills and the
    // input side has to stall.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned cyc;
        bit          held;
        cyc         = 0;
        held        = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            case ((cyc / 97) % 4)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ((cyc % 7) < 4);
            endcase
            cyc++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed words, random bursts, then drain.
    // ------------------------------------------------------------------------
    initial begin
        int count;
        int blen;
        board      = new();
        n_accepted = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_part();

        // Bursts of random length; about one burst in four runs straight into
        // the next one without a gap.
        count = 0;
        while (count < RANDOM_WORDS) begin
            blen = $urandom_range(1, 48);
            for (int j = 0; j < blen && count < RANDOM_WORDS; j++) begin
                send_word(random_word());
                count++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 9));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Wait for every predicted word, then give the pipeline time to show
        // any extra word it should not produce.
        while (board.waiting.size() != 0)
            @(posedge i_clk);
        repeat (2 * gtb_pkg::NUM_STAGES) @(posedge i_clk);
        board.flag_leftovers();

        if (board.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // The slowest correct run ends well before this limit.
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("tb_top failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/gtb_pkg.sv
rtl/gtb_tanh.sv
rtl/gelu_tanh_backward.sv
bench/tb_top.sv
